// ===== design/dcn_pkg.sv =====
package dcn_pkg;

	localparam int MAX_ITERATIONS = 50;
	localparam int SAMPLE_W = 24;
	localparam int IT_W = $clog2(MAX_ITERATIONS + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam int GC_W = 31;
	localparam int TOT_W = 31;
	localparam int IS_W = 20;
	localparam int IVT_W = 24;
	localparam int LVL_W = 16;
	localparam int THR_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_CAP_COND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOT_COND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_CUR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd5;

	localparam logic [GC_W-1:0] GC_RST = 31'd96978000;
	localparam logic [TOT_W-1:0] TOT_RST = 31'd206900000;
	localparam logic [IS_W-1:0] IS_RST = 20'd2771;
	localparam logic [IVT_W-1:0] IVT_RST = 24'd1447000;
	localparam logic [LVL_W-1:0] LVL_RST = 16'd65535;
	localparam logic [THR_W-1:0] THR_RST = 20'd10995;

	localparam int DIV_NUM_W = 62;
	localparam int DIV_DEN_W = 43;
	localparam int CUR_W = 42;

	localparam logic [CUR_W-1:0] I_LIM = '1;
	localparam logic [41:0] ARG_MAX = 42'h200_0000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP = 5'd0;
	localparam op_t OP_LOAD = 5'd1;
	localparam op_t OP_SRC0 = 5'd2;
	localparam op_t OP_SRC1 = 5'd3;
	localparam op_t OP_GD = 5'd4;
	localparam op_t OP_HA = 5'd5;
	localparam op_t OP_HB = 5'd6;
	localparam op_t OP_HC = 5'd7;
	localparam op_t OP_HD = 5'd8;
	localparam op_t OP_HE = 5'd9;
	localparam op_t OP_HF = 5'd10;
	localparam op_t OP_HG = 5'd11;
	localparam op_t OP_HH = 5'd12;
	localparam op_t OP_HI = 5'd13;
	localparam op_t OP_HFIN = 5'd14;
	localparam op_t OP_RESA = 5'd15;
	localparam op_t OP_RES_INIT = 5'd16;
	localparam op_t OP_RES_TRIAL = 5'd17;
	localparam op_t OP_DER_SETUP = 5'd18;
	localparam op_t OP_DERA = 5'd19;
	localparam op_t OP_STEP = 5'd20;
	localparam op_t OP_FINA = 5'd21;
	localparam op_t OP_FINB = 5'd22;
	localparam op_t OP_FINC = 5'd23;
	localparam op_t OP_FINW = 5'd24;

	typedef struct packed {
		op_t  op;
		logic use_gd;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic horner_last;
		logic fd_above;
		logic out_free;
	} sts_t;

	// Exact division of a 32-bit value by the Horner divisor k.
	function automatic logic [31:0] horner_recip(input logic [2:0] k);
		logic [31:0] r;
		case (k)
			3'd6: r = 32'hAAAA_AAAB;
			3'd5: r = 32'hCCCC_CCCD;
			3'd3: r = 32'hAAAA_AAAB;
			default: r = 32'd1;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] horner_shift(input logic [2:0] k);
		logic [5:0] s;
		case (k)
			3'd6: s = 6'd34;
			3'd5: s = 6'd34;
			3'd4: s = 6'd2;
			3'd3: s = 6'd33;
			3'd2: s = 6'd1;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== design/dcn_div.sv =====
module dcn_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dcn_pkg::DIV_NUM_W-1:0]  num,
	input  logic [dcn_pkg::DIV_DEN_W-1:0]  den,
	output logic [dcn_pkg::DIV_NUM_W-1:0]  quot,
	output logic                           done
);
	import dcn_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign shifted = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff = shifted - {1'b0, den_q};
	assign ge = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

// ===== design/dcn_datapath.sv =====
module dcn_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dcn_pkg::cmd_t                         cmd,
	output dcn_pkg::sts_t                         sts,
	input  logic                                  cfg_we,
	input  logic [dcn_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dcn_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [dcn_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dcn_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  not_converged
);
	import dcn_pkg::*;

	localparam logic signed [45:0] RES_HI = 46'(I_LIM);
	localparam logic signed [45:0] RES_LO = -RES_HI;
	localparam logic signed [63:0] V_HI = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] V_LO = -64'sh8000_0000;
	localparam logic signed [47:0] CAP_HI = 48'sh7F_FFFF_FFFF;
	localparam logic signed [47:0] CAP_LO = -48'sh80_0000_0000;
	localparam logic signed [47:0] Y_HI = (48'sd1 <<< (SAMPLE_W - 1)) - 48'sd1;
	localparam logic signed [47:0] Y_LO = -Y_HI - 48'sd1;

	logic [GC_W-1:0]  gc_q;
	logic [TOT_W-1:0] tot_q;
	logic [IS_W-1:0]  is_q;
	logic [IVT_W-1:0] ivt_q;
	logic [LVL_W-1:0] lvl_q;
	logic [THR_W-1:0] thr_q;

	logic signed [SAMPLE_W-1:0] vi_q;
	logic signed [41:0]         src_q;
	logic [27:0]                gd_q;
	logic signed [31:0]         vd_q;
	logic signed [39:0]         cap_q;
	logic signed [42:0]         fd_q;
	logic signed [31:0]         hv_q;
	logic [5:0]                 n_q;
	logic [29:0]                g_q;
	logic [31:0]                r_q;
	logic [2:0]                 kd_q;
	logic [CUR_W-1:0]           pos_q;
	logic [CUR_W-1:0]           hyp_q;
	logic [5:0]                 k_q;
	logic signed [65:0]         prod_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       nc_q;

	logic signed [32:0]   mul_a;
	logic signed [32:0]   mul_b;
	logic [31:0]          hv_mag;
	logic [CUR_W-1:0]     fd_mag;
	logic [55:0]          a36;
	logic [41:0]          a_cl;
	logic [25:0]          u20;
	logic [65:0]          hq_full;
	logic [27:0]          coef;
	logic [75:0]          pos_wide;
	logic [CUR_W-1:0]     pos_next;
	logic [DIV_NUM_W-1:0] div_quot;
	logic [DIV_NUM_W-1:0] neg_full;
	logic [CUR_W-1:0]     neg;
	logic [CUR_W:0]       hsum;
	logic [CUR_W-1:0]     hyp_next;
	logic signed [65:0]   p_sh16;
	logic signed [65:0]   p_sh19;
	logic signed [65:0]   p_sh20;
	logic signed [45:0]   sh_s;
	logic signed [45:0]   res_sum;
	logic signed [42:0]   res_cl;
	logic [CUR_W-1:0]     res_mag;
	logic                 res_better;
	logic [DIV_DEN_W-1:0] fdd;
	logic [DIV_DEN_W-1:0] fdd_nz;
	logic [DIV_NUM_W-1:0] step;
	logic signed [63:0]   vnew64;
	logic signed [31:0]   vnew;
	logic signed [47:0]   cap_sum;
	logic signed [39:0]   cap_next;
	logic signed [47:0]   y_full;
	logic signed [SAMPLE_W-1:0] y_next;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;

	assign hv_mag = hv_q[31] ? 32'(-hv_q) : 32'(hv_q);
	assign fd_mag = fd_q[42] ? CUR_W'(-fd_q) : CUR_W'(fd_q);

	assign a36 = prod_q[55:0];
	assign a_cl = (a36 > {14'b0, ARG_MAX}) ? ARG_MAX : a36[41:0];
	assign u20 = a_cl[41:16];

	assign hq_full = prod_q >> horner_shift(kd_q);
	assign coef = cmd.use_gd ? gd_q : {8'b0, is_q};

	assign pos_wide = (n_q >= 6'd31) ? ({15'b0, prod_q[60:0]} << (n_q - 6'd31))
	                                 : ({15'b0, prod_q[60:0]} >> (6'd31 - n_q));
	assign pos_next = (pos_wide > {34'b0, I_LIM}) ? I_LIM : pos_wide[CUR_W-1:0];

	assign neg_full = div_quot >> ({1'b0, n_q} + 7'd1);
	assign neg = (neg_full > {20'b0, I_LIM}) ? I_LIM : neg_full[CUR_W-1:0];
	assign hsum = {1'b0, pos_q} + {1'b0, neg};

	always_comb begin
		if (cmd.use_gd) begin
			hyp_next = (hsum > {1'b0, I_LIM}) ? I_LIM : hsum[CUR_W-1:0];
		end else begin
			hyp_next = (pos_q < neg) ? '0 : (pos_q - neg);
		end
	end

	assign p_sh16 = prod_q >>> 16;
	assign p_sh19 = prod_q >>> 19;
	assign p_sh20 = prod_q >>> 20;

	assign sh_s = hv_q[31] ? -$signed({4'b0, hyp_q}) : $signed({4'b0, hyp_q});
	assign res_sum = $signed(p_sh20[45:0]) + sh_s - {{4{src_q[41]}}, src_q};

	always_comb begin
		if (res_sum > RES_HI) begin
			res_cl = 43'(RES_HI);
		end else if (res_sum < RES_LO) begin
			res_cl = 43'(RES_LO);
		end else begin
			res_cl = res_sum[42:0];
		end
	end

	assign res_mag = res_cl[42] ? CUR_W'(-res_cl) : CUR_W'(res_cl);
	assign res_better = res_mag < fd_mag;

	assign fdd = {1'b0, hyp_q} + {12'b0, tot_q};
	assign fdd_nz = (fdd == '0) ? DIV_DEN_W'(1) : fdd;

	assign step = div_quot >> k_q;
	assign vnew64 = fd_q[42] ? ({{32{vd_q[31]}}, vd_q} + $signed({2'b0, step}))
	                         : ({{32{vd_q[31]}}, vd_q} - $signed({2'b0, step}));

	always_comb begin
		if (vnew64 > V_HI) begin
			vnew = 32'(V_HI);
		end else if (vnew64 < V_LO) begin
			vnew = 32'(V_LO);
		end else begin
			vnew = vnew64[31:0];
		end
	end

	assign cap_sum = $signed(p_sh19[47:0]) - {{8{cap_q[39]}}, cap_q};

	always_comb begin
		if (cap_sum > CAP_HI) begin
			cap_next = 40'(CAP_HI);
		end else if (cap_sum < CAP_LO) begin
			cap_next = 40'(CAP_LO);
		end else begin
			cap_next = cap_sum[39:0];
		end
	end

	assign y_full = $signed(p_sh16[47:0]);

	always_comb begin
		if (y_full > Y_HI) begin
			y_next = SAMPLE_W'(Y_HI);
		end else if (y_full < Y_LO) begin
			y_next = SAMPLE_W'(Y_LO);
		end else begin
			y_next = y_full[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SRC0: begin
				mul_a = {{(33 - SAMPLE_W){vi_q[SAMPLE_W-1]}}, vi_q};
				mul_b = {2'b0, gc_q};
			end
			OP_SRC1: begin
				mul_a = {13'b0, is_q};
				mul_b = {9'b0, ivt_q};
			end
			OP_HA: begin
				mul_a = {1'b0, hv_mag};
				mul_b = {9'b0, ivt_q};
			end
			OP_HB: begin
				mul_a = {7'b0, u20};
				mul_b = {2'b0, LOG2E_Q30};
			end
			OP_HC: begin
				mul_a = {13'b0, prod_q[49:30]};
				mul_b = {3'b0, LN2_Q30};
			end
			OP_HE: begin
				mul_a = {3'b0, g_q};
				mul_b = {1'b0, r_q};
			end
			OP_HF: begin
				mul_a = {1'b0, prod_q[61:30]};
				mul_b = {1'b0, horner_recip(kd_q)};
			end
			OP_HH: begin
				mul_a = {5'b0, coef};
				mul_b = {1'b0, r_q};
			end
			OP_RESA: begin
				mul_a = {hv_q[31], hv_q};
				mul_b = {2'b0, tot_q};
			end
			OP_FINA: begin
				mul_a = {vd_q[31], vd_q};
				mul_b = {2'b0, gc_q};
			end
			OP_FINB, OP_FINW: begin
				mul_a = {vd_q[31], vd_q};
				mul_b = {17'b0, lvl_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (cmd.op == OP_HH) || (cmd.op == OP_DERA);
	assign div_num = (cmd.op == OP_HH) ? {4'b0, coef, 30'b0} : {fd_mag, 20'b0};
	assign div_den = (cmd.op == OP_HH) ? {11'b0, r_q} : fdd_nz;

	dcn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= GC_RST;
			tot_q <= TOT_RST;
			is_q <= IS_RST;
			ivt_q <= IVT_RST;
			lvl_q <= LVL_RST;
			thr_q <= THR_RST;
			vd_q <= '0;
			cap_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CAP_COND: gc_q <= cfg_data[GC_W-1:0];
					REG_TOT_COND: tot_q <= cfg_data[TOT_W-1:0];
					REG_SAT_CUR: is_q <= cfg_data[IS_W-1:0];
					REG_INV_VT: ivt_q <= cfg_data[IVT_W-1:0];
					REG_LEVEL: lvl_q <= cfg_data[LVL_W-1:0];
					REG_THRESH: thr_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LOAD: k_q <= '0;
				OP_RES_TRIAL: begin
					if (res_better) begin
						vd_q <= hv_q;
						k_q <= '0;
					end else if (k_q != 6'd63) begin
						k_q <= k_q + 6'd1;
					end
				end
				OP_FINB: cap_q <= cap_next;
				default: ;
			endcase
			if (cmd.op == OP_FINC) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: vi_q <= sample_in;
			OP_SRC1: src_q <= $signed(p_sh20[41:0]) + {{2{cap_q[39]}}, cap_q};
			OP_GD: begin
				gd_q <= prod_q[43:16];
				hv_q <= vd_q;
			end
			OP_DER_SETUP: hv_q <= vd_q;
			OP_HC: n_q <= prod_q[55:50];
			OP_HD: begin
				g_q <= prod_q[49:20];
				r_q <= ONE_Q30;
				kd_q <= 3'd6;
			end
			OP_HG: begin
				r_q <= ONE_Q30 + hq_full[31:0];
				kd_q <= kd_q - 3'd1;
			end
			OP_HI: pos_q <= pos_next;
			OP_HFIN: hyp_q <= hyp_next;
			OP_STEP: hv_q <= vnew;
			OP_RES_INIT: fd_q <= res_cl;
			OP_RES_TRIAL: begin
				if (res_better) begin
					fd_q <= res_cl;
				end
			end
			OP_FINC: begin
				sample_out_q <= y_next;
				nc_q <= sts.fd_above;
			end
			default: ;
		endcase
	end

	assign sts.div_done = div_done;
	assign sts.horner_last = kd_q == 3'd1;
	assign sts.fd_above = fd_mag > {22'b0, thr_q};
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign not_converged = nc_q;

endmodule

// ===== design/dcn_ctrl.sv =====
module dcn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output dcn_pkg::cmd_t cmd,
	input  dcn_pkg::sts_t sts
);
	import dcn_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SRC0 = 5'd1;
	localparam logic [4:0] ST_SRC1 = 5'd2;
	localparam logic [4:0] ST_GD = 5'd3;
	localparam logic [4:0] ST_HA = 5'd4;
	localparam logic [4:0] ST_HB = 5'd5;
	localparam logic [4:0] ST_HC = 5'd6;
	localparam logic [4:0] ST_HD = 5'd7;
	localparam logic [4:0] ST_HE = 5'd8;
	localparam logic [4:0] ST_HF = 5'd9;
	localparam logic [4:0] ST_HG = 5'd10;
	localparam logic [4:0] ST_HH = 5'd11;
	localparam logic [4:0] ST_HI = 5'd12;
	localparam logic [4:0] ST_HW = 5'd13;
	localparam logic [4:0] ST_RESA = 5'd14;
	localparam logic [4:0] ST_RESB = 5'd15;
	localparam logic [4:0] ST_CHECK = 5'd16;
	localparam logic [4:0] ST_DERA = 5'd17;
	localparam logic [4:0] ST_DERW = 5'd18;
	localparam logic [4:0] ST_FINA = 5'd19;
	localparam logic [4:0] ST_FINB = 5'd20;
	localparam logic [4:0] ST_FINC = 5'd21;

	localparam logic [1:0] PUR_INIT = 2'd0;
	localparam logic [1:0] PUR_DER = 2'd1;
	localparam logic [1:0] PUR_TRIAL = 2'd2;

	logic [4:0]      state_q;
	logic [4:0]      state_next;
	logic [1:0]      pur_q;
	logic [1:0]      pur_next;
	logic [IT_W-1:0] it_q;
	logic [IT_W-1:0] it_next;

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_next = state_q;
		pur_next = pur_q;
		it_next = it_q;
		cmd.op = OP_NOP;
		cmd.use_gd = pur_q == PUR_DER;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					it_next = '0;
					state_next = ST_SRC0;
				end
			end
			ST_SRC0: begin
				cmd.op = OP_SRC0;
				state_next = ST_SRC1;
			end
			ST_SRC1: begin
				cmd.op = OP_SRC1;
				state_next = ST_GD;
			end
			ST_GD: begin
				cmd.op = OP_GD;
				pur_next = PUR_INIT;
				state_next = ST_HA;
			end
			ST_HA: begin
				cmd.op = OP_HA;
				state_next = ST_HB;
			end
			ST_HB: begin
				cmd.op = OP_HB;
				state_next = ST_HC;
			end
			ST_HC: begin
				cmd.op = OP_HC;
				state_next = ST_HD;
			end
			ST_HD: begin
				cmd.op = OP_HD;
				state_next = ST_HE;
			end
			ST_HE: begin
				cmd.op = OP_HE;
				state_next = ST_HF;
			end
			ST_HF: begin
				cmd.op = OP_HF;
				state_next = ST_HG;
			end
			ST_HG: begin
				cmd.op = OP_HG;
				state_next = sts.horner_last ? ST_HH : ST_HE;
			end
			ST_HH: begin
				cmd.op = OP_HH;
				state_next = ST_HI;
			end
			ST_HI: begin
				cmd.op = OP_HI;
				state_next = ST_HW;
			end
			ST_HW: begin
				if (sts.div_done) begin
					cmd.op = OP_HFIN;
					state_next = (pur_q == PUR_DER) ? ST_DERA : ST_RESA;
				end
			end
			ST_RESA: begin
				cmd.op = OP_RESA;
				state_next = ST_RESB;
			end
			ST_RESB: begin
				if (pur_q == PUR_TRIAL) begin
					cmd.op = OP_RES_TRIAL;
					it_next = it_q + IT_W'(1);
				end else begin
					cmd.op = OP_RES_INIT;
				end
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if ((it_q < IT_W'(MAX_ITERATIONS)) && sts.fd_above) begin
					cmd.op = OP_DER_SETUP;
					pur_next = PUR_DER;
					state_next = ST_HA;
				end else begin
					state_next = ST_FINA;
				end
			end
			ST_DERA: begin
				cmd.op = OP_DERA;
				state_next = ST_DERW;
			end
			ST_DERW: begin
				if (sts.div_done) begin
					cmd.op = OP_STEP;
					cmd.use_gd = 1'b0;
					pur_next = PUR_TRIAL;
					state_next = ST_HA;
				end
			end
			ST_FINA: begin
				cmd.op = OP_FINA;
				state_next = ST_FINB;
			end
			ST_FINB: begin
				cmd.op = OP_FINB;
				state_next = ST_FINC;
			end
			ST_FINC: begin
				if (sts.out_free) begin
					cmd.op = OP_FINC;
					state_next = ST_IDLE;
				end else begin
					cmd.op = OP_FINW;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pur_q <= PUR_INIT;
			it_q <= '0;
		end else begin
			state_q <= state_next;
			pur_q <= pur_next;
			it_q <= it_next;
		end
	end

endmodule

// ===== design/diode_clipper_newton_solver_unit.sv =====
// Diode clipper solver: one damped Newton solve per audio sample.
// The input channel (in_valid, in_stall, sample_in) takes one request when
// the unit is idle; in_stall stays high while a sample is being solved.
// The output channel (out_valid, out_stall, sample_out, not_converged)
// holds each result in an output register until the receiver takes it, so
// a stalled receiver does not block acceptance of the next request.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes one register per request; cfg_ready is always high and writes are
// meant to happen only while the unit is idle.
// At most 50 Newton iterations run per sample; one sample is solved at a time.
// Each iteration evaluates two exponential terms and one step quotient, and
// each of those runs through the shared radix-2 divider, while the six-step
// Horner loop uses the single shared 33 by 33 bit multiplier.
// Reset loads the register defaults and clears the diode voltage and the
// capacitor state. When the receiver stalls a finished result, the next
// result waits in the solver until the output register frees up.
module diode_clipper_newton_solver_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [dcn_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dcn_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                 not_converged,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dcn_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dcn_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dcn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	dcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	dcn_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_in     (sample_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.not_converged (not_converged)
	);

endmodule

// ===== test/diode_clipper_newton_solver_unit_test.sv =====
`timescale 1ns / 100ps

module diode_clipper_newton_solver_unit_test;
	import dcn_pkg::*;

	localparam longint unsigned CUR_LIMIT = 64'd4398046511103;
	localparam longint unsigned ARG_LIMIT = 64'd32 << 36;
	localparam longint unsigned LOG2E_FX = 64'd1549082005;
	localparam longint unsigned LN2_FX = 64'd744261118;
	localparam longint unsigned UNITY_Q30 = 64'd1 << 30;
	localparam longint CAP_LIMIT = 64'sd549755813887;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [SAMPLE_W-1:0] level;
		logic                       clip_fail;
	} clip_result_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] level;
		logic                       clip_fail;
	} sample_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic not_converged;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	diode_clipper_newton_solver_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .not_converged(not_converged),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	longint unsigned clip_regs [6];
	longint diode_v;
	longint cap_state;
	clip_result_t pending_q[$];
	sample_row_t typed_q[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic longint absv(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clampv(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint hyper_term(input longint unsigned c, input longint unsigned a,
			input bit want_cosh);
		longint unsigned u, t, f, g, r, v, pos, neg;
		int n;
		if (a > ARG_LIMIT)
			a = ARG_LIMIT;
		u = a >> 16;
		t = (u * LOG2E_FX) >> 30;
		n = int'(t >> 20);
		f = t & 64'hFFFFF;
		g = (f * LN2_FX) >> 20;
		r = UNITY_Q30;
		for (int k = 6; k >= 1; k--)
			r = UNITY_Q30 + ((g * r) >> 30) / longint'(k);
		v = c * r;
		if (n >= 31)
			pos = (v > (CUR_LIMIT >> (n - 31))) ? CUR_LIMIT : (v << (n - 31));
		else
			pos = v >> (31 - n);
		if (pos > CUR_LIMIT)
			pos = CUR_LIMIT;
		neg = ((c << 30) / r) >> (n + 1);
		if (want_cosh) begin
			v = pos + neg;
			return longint'(v > CUR_LIMIT ? CUR_LIMIT : v);
		end
		return pos < neg ? 0 : longint'(pos - neg);
	endfunction

	function automatic longint diode_residual(input longint v, input longint src);
		longint sh;
		longint f;
		sh = hyper_term(clip_regs[2], longint'(absv(v)) * clip_regs[3], 0);
		if (v < 0)
			sh = -sh;
		f = (($signed(clip_regs[1]) * v) >>> 20) + sh - src;
		return clampv(f, -longint'(CUR_LIMIT), longint'(CUR_LIMIT));
	endfunction

	function automatic clip_result_t solve_sample(input logic signed [SAMPLE_W-1:0] s);
		clip_result_t res;
		longint vi, src, vd, fd, fn, vnew, y, thr;
		longint unsigned gd, deriv, stp;
		int k;
		vi = s;
		thr = $signed(clip_regs[5]);
		k = 0;
		src = ((vi * $signed(clip_regs[0])) >>> 20) + cap_state;
		gd = (clip_regs[2] * clip_regs[3]) >> 16;
		vd = diode_v;
		fd = diode_residual(vd, src);
		for (int i = 0; i < MAX_ITERATIONS && absv(fd) > thr; i++) begin
			deriv = longint'(hyper_term(gd, absv(vd) * clip_regs[3], 1)) + clip_regs[1];
			if (deriv == 0)
				deriv = 1;
			stp = ((longint'(absv(fd)) << 20) / deriv) >> k;
			vnew = fd < 0 ? vd + $signed(stp) : vd - $signed(stp);
			vnew = clampv(vnew, -64'sd2147483648, 64'sd2147483647);
			fn = diode_residual(vnew, src);
			if (absv(fn) < absv(fd)) begin
				vd = vnew;
				fd = fn;
				k = 0;
			end else if (k < 63) begin
				k++;
			end
		end
		diode_v = vd;
		cap_state = clampv(((vd * $signed(clip_regs[0])) >>> 19) - cap_state,
			-CAP_LIMIT - 1, CAP_LIMIT);
		y = clampv((vd * $signed(clip_regs[4])) >>> 16, -64'sd8388608, 64'sd8388607);
		res.level = y[SAMPLE_W-1:0];
		res.clip_fail = absv(fd) > thr;
		return res;
	endfunction

	function automatic void write_clip_reg(input int idx, input longint unsigned value);
		int w;
		case (idx)
			REG_CAP_COND: w = GC_W;
			REG_TOT_COND: w = TOT_W;
			REG_SAT_CUR: w = IS_W;
			REG_INV_VT: w = IVT_W;
			REG_LEVEL: w = LVL_W;
			REG_THRESH: w = THR_W;
			default: w = 0;
		endcase
		if (w > 0)
			clip_regs[idx] = value & ((64'd1 << w) - 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clip_result_t want;
		clip_result_t typed_res;
		sample_row_t row;
		if (!arst_n) begin
			clip_regs[0] = GC_RST;
			clip_regs[1] = TOT_RST;
			clip_regs[2] = IS_RST;
			clip_regs[3] = IVT_RST;
			clip_regs[4] = LVL_RST;
			clip_regs[5] = THR_RST;
			diode_v = 0;
			cap_state = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_clip_reg(int'(cfg_index), 64'(cfg_data));
			if (in_valid && !in_stall) begin
				want = solve_sample(sample_in);
				if (typed_q.size() > 0 && typed_q[0].sample == sample_in) begin
					row = typed_q.pop_front();
					if (row.typed) begin
						want.level = row.level;
						want.clip_fail = row.clip_fail;
					end
				end
				pending_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: sample_out=%0d not_converged=%0b",
							sample_out, not_converged);
				end else begin
					want = pending_q.pop_front();
					if (want.level !== sample_out || want.clip_fail !== not_converged) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: sample_out exp %0d got %0d, not_converged exp %0b got %0b",
								want.level, sample_out, want.clip_fail, not_converged);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else begin
			out_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout");
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			sample_in <= SAMPLE_W'($urandom);
			@(negedge clk);
		end
		in_valid <= 1;
		sample_in <= s;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_q.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample;
		case ($urandom_range(3))
			0: return SAMPLE_W'($urandom);
			1: return SAMPLE_W'($signed($urandom_range(65535)) - 32768);
			2: return SAMPLE_W'($signed($urandom_range(2097151)) - 1048576);
			default: return SAMPLE_W'($signed($urandom_range(8388607)) - 4194304);
		endcase
	endfunction

	task automatic random_config(input bit wide);
		write_reg(REG_CAP_COND,
			CFG_DATA_W'(wide ? $urandom : 50000000 + $urandom_range(100000000)));
		write_reg(REG_TOT_COND,
			CFG_DATA_W'(wide ? $urandom : 150000000 + $urandom_range(200000000)));
		write_reg(REG_SAT_CUR, CFG_DATA_W'(wide ? $urandom : 500 + $urandom_range(8000)));
		write_reg(REG_INV_VT,
			CFG_DATA_W'(wide ? $urandom : 800000 + $urandom_range(1000000)));
		write_reg(REG_LEVEL, CFG_DATA_W'($urandom));
		write_reg(REG_THRESH, CFG_DATA_W'(wide ? $urandom : 2000 + $urandom_range(40000)));
	endtask

	sample_row_t directed [] = '{
		'{sample: 24'sd0, typed: 1, level: 24'sd0, clip_fail: 1'b0},
		'{sample: 24'sd8388607, typed: 0, level: 0, clip_fail: 0},
		'{sample: -24'sd8388608, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd1, typed: 0, level: 0, clip_fail: 0},
		'{sample: -24'sd1, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd1048576, typed: 0, level: 0, clip_fail: 0},
		'{sample: -24'sd1048576, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd262144, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd8388607, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd0, typed: 0, level: 0, clip_fail: 0},
		'{sample: -24'sd4194304, typed: 0, level: 0, clip_fail: 0},
		'{sample: 24'sd4194304, typed: 0, level: 0, clip_fail: 0}
	};

	initial begin
		int idle_mode;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		foreach (directed[i]) begin
			typed_q.push_back(directed[i]);
			send_sample(directed[i].sample);
		end
		drain();
		typed_q.delete();

		for (int phase = 0; phase < 9; phase++) begin
			idle_mode = phase % 4;
			send_idle_pct = (idle_mode == 1 || idle_mode == 3) ? (idle_mode == 1 ? 74 : 31) : 0;
			recv_stall_pct = (idle_mode == 2 || idle_mode == 3) ? (idle_mode == 2 ? 74 : 31) : 0;
			case (phase)
				0: ;
				3: begin
					write_reg(REG_CAP_COND, '1);
					write_reg(REG_TOT_COND, '1);
					write_reg(REG_SAT_CUR, '1);
					write_reg(REG_INV_VT, '1);
					write_reg(REG_LEVEL, '1);
					write_reg(REG_THRESH, '1);
					write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
				end
				5: begin
					write_reg(REG_CAP_COND, '0);
					write_reg(REG_TOT_COND, '0);
					write_reg(REG_SAT_CUR, '0);
					write_reg(REG_INV_VT, '0);
					write_reg(REG_LEVEL, '0);
					write_reg(REG_THRESH, '0);
					write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
				end
				6: random_config(1);
				default: random_config(0);
			endcase
			if (phase == 2)
				hold_request = 1;
			for (int n = 0; n < ((phase == 3 || phase == 5 || phase == 6) ? 30 : 170); n++)
				send_sample(random_sample());
			drain();
		end

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== diode_clipper_newton_solver_unit.f =====
design/dcn_pkg.sv
design/dcn_div.sv
design/dcn_datapath.sv
design/dcn_ctrl.sv
design/diode_clipper_newton_solver_unit.sv
test/diode_clipper_newton_solver_unit_test.sv
